/* rtl/core/smp_pkg.sv */
// ----------------------------------------------------------------------------
// smp_pkg: shared definitions for segment max pooling
// Constants, item types and register codes used by every module but smp_ram.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int MaxRowWidth   = 1024;
  localparam int MaxSegments   = 256;
  localparam int ValueBits     = 16;

  localparam int ColBits       = $clog2(MaxRowWidth);
  localparam int SegCountBits  = $clog2(MaxSegments);
  localparam int RowWidthBits  = 11;
  localparam int SegsBits      = 9;
  localparam int ApbAddrBits   = 3;
  localparam int ApbDataBits   = 32;

  localparam logic [RowWidthBits-1:0] RowWidthReset = RowWidthBits'(768);
  localparam logic [SegsBits-1:0]     SegsReset     = SegsBits'(256);
  localparam logic [SegsBits-1:0]     SegsLimit     = SegsBits'(MaxSegments);

  typedef enum logic [0:0] {
    RegRowWidth = 1'b0,
    RegSegsPerBatch = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic [ColBits-1:0]          column;
    logic                        seg_first;
    logic                        seg_last;
    logic                        empty_segment;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] pooled;
    logic [ColBits-1:0]          out_column;
    logic                        row_end;
    logic                        batch_end;
  } out_item_t;

  typedef struct packed {
    logic [RowWidthBits-1:0] row_width;
    logic [SegsBits-1:0]     segments_per_batch;
  } cfg_t;

endpackage

/* rtl/core/smp_ram.sv */
// ----------------------------------------------------------------------------
// smp_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module smp_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/smp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// smp_cfg_regs: configuration registers
// APB-style register file holding the row width and segments per batch.
// ----------------------------------------------------------------------------
module smp_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [smp_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [smp_pkg::ApbDataBits-1:0]    pwdata,
  output logic [smp_pkg::ApbDataBits-1:0]    prdata,
  output logic                               pready,
  output smp_pkg::cfg_t                      cfg_o
);

  smp_pkg::cfg_t     cfg_q, cfg_d;
  smp_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = smp_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        smp_pkg::RegRowWidth: begin
          cfg_d.row_width = pwdata[smp_pkg::RowWidthBits-1:0];
        end
        smp_pkg::RegSegsPerBatch: begin
          cfg_d.segments_per_batch = pwdata[smp_pkg::SegsBits-1:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      smp_pkg::RegRowWidth: begin
        prdata = smp_pkg::ApbDataBits'(cfg_q.row_width);
      end
      smp_pkg::RegSegsPerBatch: begin
        prdata = smp_pkg::ApbDataBits'(cfg_q.segments_per_batch);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width          <= smp_pkg::RowWidthReset;
      cfg_q.segments_per_batch <= smp_pkg::SegsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/smp_pool_core.sv */
// ----------------------------------------------------------------------------
// smp_pool_core: running-maximum datapath
// Reads the column's running maximum from RAM, updates it in the s1 stage with
// forwarding of the most recent write, and registers the pooled result.
// ----------------------------------------------------------------------------
module smp_pool_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smp_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smp_pkg::out_item_t  out_item_o
);

  // The forwarding register always holds the latest write, so it matches
  // the RAM contents for its address and can be used once fwd_valid_q is set.
  logic                                  s1_valid_q;
  smp_pkg::in_item_t                     s1_item_q;
  logic                                  fwd_valid_q;
  logic [smp_pkg::ColBits-1:0]           fwd_addr_q;
  logic signed [smp_pkg::ValueBits-1:0]  fwd_data_q;
  logic [smp_pkg::SegCountBits-1:0]      seg_count_q, seg_count_d;
  logic                                  out_valid_q;
  smp_pkg::out_item_t                    out_item_q;

  logic [smp_pkg::ValueBits-1:0]         rdata;
  logic signed [smp_pkg::ValueBits-1:0]  old_max;
  logic signed [smp_pkg::ValueBits-1:0]  new_max;
  logic                                  emit;
  logic                                  out_free;
  logic                                  s1_adv;
  logic                                  accept;
  logic                                  mem_we;
  logic                                  row_end;
  logic                                  batch_end;
  logic                                  spb_ok;
  smp_pkg::out_item_t                    result;

  smp_ram #(
    .Width (smp_pkg::ValueBits),
    .Depth (smp_pkg::MaxRowWidth)
  ) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_item_q.column),
    .wdata_i (new_max),
    .re_i    (accept),
    .raddr_i (in_item_i.column),
    .rdata_o (rdata)
  );

  always_comb begin
    old_max = (fwd_valid_q && (fwd_addr_q == s1_item_q.column)) ? fwd_data_q
                                                                 : $signed(rdata);
    new_max = (!s1_item_q.seg_first && (old_max >= s1_item_q.value)) ? old_max
                                                                     : s1_item_q.value;
  end

  assign emit       = s1_valid_q && (s1_item_q.empty_segment || s1_item_q.seg_last);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign mem_we     = s1_adv && !s1_item_q.empty_segment;

  always_comb begin
    row_end   = (cfg_i.row_width != '0) &&
                ({1'b0, s1_item_q.column} == (cfg_i.row_width - 1'b1));
    spb_ok    = (cfg_i.segments_per_batch != '0) &&
                (cfg_i.segments_per_batch <= smp_pkg::SegsLimit);
    batch_end = row_end && spb_ok &&
                ({1'b0, seg_count_q} == (cfg_i.segments_per_batch - 1'b1));
    seg_count_d = seg_count_q;
    if (emit && s1_adv && row_end) begin
      seg_count_d = batch_end ? '0 : seg_count_q + 1'b1;
    end
    result.pooled     = s1_item_q.empty_segment ? '0 : new_max;
    result.out_column = s1_item_q.column;
    result.row_end    = row_end;
    result.batch_end  = batch_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      seg_count_q <= '0;
    end else begin
      seg_count_q <= seg_count_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (mem_we) begin
        fwd_valid_q <= 1'b1;
      end
      if (emit && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (mem_we) begin
      fwd_addr_q <= s1_item_q.column;
      fwd_data_q <= new_max;
    end
    if (emit && s1_adv) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/core/segment_max_pooling_unit.sv */
// ----------------------------------------------------------------------------
// segment_max_pooling_unit: segment max pooling, top level
// Keeps a running maximum per column over each segment and emits the pooled
// row, flagging row and batch ends.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  smp_pkg::in_item_t
//   out      source     out_valid_o/out_stall_i smp_pkg::out_item_t
//   cfg      sink       APB (psel, penable)    row_width, segments_per_batch
//
// One item is accepted per cycle while in_stall_o is low.
// The column's RAM maximum is read on acceptance and written back when it
// leaves s1, with the latest write forwarded to cover back-to-back columns.
// The RAM content is undefined after reset and needs no clearing.
// A stalled output register holds the input only when the waiting item emits.
// ----------------------------------------------------------------------------
module segment_max_pooling_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  smp_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output smp_pkg::out_item_t               out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smp_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [smp_pkg::ApbDataBits-1:0]  pwdata,
  output logic [smp_pkg::ApbDataBits-1:0]  prdata,
  output logic                             pready
);

  smp_pkg::cfg_t cfg;

  smp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  smp_pool_core u_pool_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for segment_max_pooling_unit
// Streams feature elements through the block and predicts every pooled
// result from a local copy of the per-column maxima and the segment counter.
// A short directed part is followed by random well-formed segments under
// several register settings, mixed with stray items, random gaps on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import smp_pkg::*;

  localparam int CycleLimit  = 800000;
  localparam int DrainCycles = 8;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_item_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_item_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [ApbAddrBits-1:0] paddr       = '0;
  logic [ApbDataBits-1:0] pwdata      = '0;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  logic signed [ValueBits-1:0] col_max [MaxRowWidth];
  bit                          col_seen [MaxRowWidth];
  logic [SegCountBits-1:0]     seg_cnt       = '0;
  logic [RowWidthBits-1:0]     cur_row_width = RowWidthReset;
  logic [SegsBits-1:0]         cur_segs      = SegsReset;
  out_item_t                   pending_pooled [$];
  int                          row_cols [$];

  int err_cnt      = 0;
  int cycle_cnt    = 0;
  bit tx_gaps_on   = 1'b0;
  bit rx_stalls_on = 1'b0;
  int rx_hold_req  = 0;
  int stall_left   = 0;

  segment_max_pooling_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** segment_max_pooling_unit: FAILED **");
      $finish;
    end
  end

  function automatic void compute_pooled(in_item_t it);
    out_item_t                   res;
    logic signed [ValueBits-1:0] m;
    m = '0;
    if (!it.empty_segment) begin
      m = it.value;
      if (!it.seg_first && $signed(col_max[it.column]) >= $signed(it.value)) begin
        m = col_max[it.column];
      end
      col_max[it.column]  = m;
      col_seen[it.column] = 1'b1;
      if (!it.seg_last) begin
        return;
      end
    end
    res.pooled     = m;
    res.out_column = it.column;
    res.row_end    = (int'(cur_row_width) != 0) &&
                     (int'(it.column) == int'(cur_row_width) - 1);
    res.batch_end  = 1'b0;
    if (res.row_end) begin
      if (int'(cur_segs) != 0 && int'(cur_segs) <= MaxSegments &&
          int'(seg_cnt) == int'(cur_segs) - 1) begin
        res.batch_end = 1'b1;
        seg_cnt       = '0;
      end else begin
        seg_cnt = seg_cnt + 1'b1;
      end
    end
    pending_pooled.push_back(res);
  endfunction

  always @(posedge clk_i) begin : pooled_checker
    out_item_t want;
    bit        stall_next;
    int        r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pooled.size() == 0) begin
        $error("unexpected result for column %0d", out_item_o.out_column);
        err_cnt++;
      end else begin
        want = pending_pooled.pop_front();
        if (out_item_o.pooled !== want.pooled) begin
          $error("pooled: expected %0d, got %0d", $signed(want.pooled),
                 $signed(out_item_o.pooled));
          err_cnt++;
        end
        if (out_item_o.out_column !== want.out_column) begin
          $error("out_column: expected %0d, got %0d", want.out_column,
                 out_item_o.out_column);
          err_cnt++;
        end
        if (out_item_o.row_end !== want.row_end) begin
          $error("row_end: expected %0d, got %0d", want.row_end, out_item_o.row_end);
          err_cnt++;
        end
        if (out_item_o.batch_end !== want.batch_end) begin
          $error("batch_end: expected %0d, got %0d", want.batch_end,
                 out_item_o.batch_end);
          err_cnt++;
        end
      end
    end
    stall_next = 1'b0;
    if (stall_left != 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (rx_hold_req != 0) begin
      stall_left  = rx_hold_req - 1;
      rx_hold_req = 0;
      stall_next  = 1'b1;
    end else if (rx_stalls_on) begin
      r = $urandom_range(0, 99);
      if (r >= 97) begin
        stall_left = $urandom_range(15, 40);
        stall_next = 1'b1;
      end else if (r >= 70) begin
        stall_left = $urandom_range(0, 3);
        stall_next = 1'b1;
      end
    end
    out_stall_i <= stall_next;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [ValueBits-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 16'h8000;
    end else if (r < 16) begin
      return 16'h7fff;
    end else if (r < 20) begin
      return 16'h0000;
    end else if (r < 24) begin
      return 16'hffff;
    end else if (r < 40) begin
      return ValueBits'($urandom_range(0, 15) - 8);
    end
    return ValueBits'($urandom);
  endfunction

  function automatic in_item_t make_item(logic [ValueBits-1:0] v, int col, bit f, bit l,
                                         bit e);
    in_item_t it;
    it.value         = v;
    it.column        = ColBits'(col);
    it.seg_first     = f;
    it.seg_last      = l;
    it.empty_segment = e;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    compute_pooled(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pooled.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    logic [ApbDataBits-1:0] data;
    data = ApbDataBits'(val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrBits'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRowWidth: begin
        cur_row_width = data[RowWidthBits-1:0];
      end
      RegSegsPerBatch: begin
        cur_segs = data[SegsBits-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_config(int unsigned rw, int unsigned segs);
    wait_idle();
    write_reg(RegRowWidth, rw);
    write_reg(RegSegsPerBatch, segs);
  endtask

  // Rows of 1 to 16 columns are sent whole; others are sent as one to four
  // sorted columns, ended by the last column when in range, so row ends occur.
  task automatic build_row(int rw);
    int top;
    row_cols.delete();
    if (rw >= 1 && rw <= 16) begin
      for (int c = 0; c < rw; c++) begin
        row_cols.push_back(c);
      end
    end else begin
      top = (rw >= 1 && rw <= MaxRowWidth) ? rw - 1 : MaxRowWidth - 1;
      repeat ($urandom_range(1, 4)) row_cols.push_back($urandom_range(0, top));
      row_cols.sort();
      if (rw >= 1 && rw <= MaxRowWidth) begin
        row_cols.push_back(top);
      end
    end
  endtask

  task automatic send_segment(int rows, bit emp);
    if (emp) begin
      foreach (row_cols[i]) begin
        send_item(make_item(rand_value(), row_cols[i], 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1));
      end
    end else begin
      for (int r = 0; r < rows; r++) begin
        foreach (row_cols[i]) begin
          send_item(make_item(rand_value(), row_cols[i], r == 0, r == rows - 1, 1'b0));
        end
      end
    end
  endtask

  // A stray item never continues a column whose maximum was never loaded.
  task automatic send_noise();
    in_item_t it;
    it = make_item(rand_value(), $urandom_range(0, MaxRowWidth - 1),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) == 0);
    if (!it.empty_segment && !it.seg_first && !col_seen[it.column]) begin
      it.seg_first = 1'b1;
    end
    send_item(it);
  endtask

  task automatic run_phase(int rw, int segs, int n_items, bit gaps, bit stalls,
                           int max_rows);
    int sent;
    int rows;
    int r;
    bit emp;
    set_config(rw, segs);
    tx_gaps_on   = gaps;
    rx_stalls_on = stalls;
    sent         = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        send_noise();
        sent++;
      end else begin
        build_row(rw);
        r = $urandom_range(0, 99);
        if (max_rows == 1 || r < 40) begin
          rows = 1;
        end else if (r < 80) begin
          rows = $urandom_range(2, (max_rows < 3) ? max_rows : 3);
        end else begin
          rows = $urandom_range(2, max_rows);
        end
        emp = ($urandom_range(0, 99) < 12);
        send_segment(rows, emp);
        sent += emp ? row_cols.size() : rows * row_cols.size();
      end
    end
  endtask

  task automatic test_directed_cases();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // Registers still hold their reset values here.
    send_item(make_item(16'h7fff, 0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(16'h8000, 767, 1'b1, 1'b1, 1'b0));
    send_item(make_item(16'h0100, 1023, 1'b1, 1'b0, 1'b0));
    send_item(make_item(16'h8000, 1023, 1'b0, 1'b1, 1'b0));
    send_item(make_item(16'hfffb, 5, 1'b1, 1'b0, 1'b0));
    send_item(make_item(16'h0003, 5, 1'b0, 1'b0, 1'b0));
    send_item(make_item(16'h0003, 5, 1'b0, 1'b1, 1'b0));
    send_item(make_item(16'h04d2, 5, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'hff9c, 5, 1'b0, 1'b1, 1'b0));
    send_item(make_item(16'h1234, 767, 1'b0, 1'b0, 1'b1));
    send_item(make_item(16'h5555, 341, 1'b1, 1'b1, 1'b0));
    send_item(make_item(16'haaaa, 682, 1'b1, 1'b1, 1'b0));
    set_config(1, 3);
    send_item(make_item(16'h0080, 0, 1'b1, 1'b1, 1'b0));
    set_config(1, 1);
    send_item(make_item(16'h0000, 0, 1'b0, 1'b0, 1'b1));
    send_item(make_item(16'h0042, 1, 1'b1, 1'b1, 1'b0));
    set_config(1024, 2);
    send_item(make_item(16'hffff, 1023, 1'b1, 1'b1, 1'b0));
    send_item(make_item(16'h0001, 1023, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_full_backpressure();
    set_config(2, 3);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req  = 200;
    for (int k = 0; k < 80; k++) begin
      send_item(make_item(rand_value(), k % 2, 1'b1, 1'b1, 1'b0));
    end
    wait_idle();
  endtask

  task automatic test_random_segments();
    run_phase(4, 3, 200, 1'b1, 1'b1, 8);
    run_phase(1, 1, 80, 1'b1, 1'b1, 4);
    run_phase(1, 256, 330, 1'b1, 1'b1, 1);
    run_phase(1024, 2, 160, 1'b1, 1'b1, 4);
    run_phase(0, 4, 100, 1'b1, 1'b1, 4);
    run_phase(2047, 511, 90, 1'b1, 1'b0, 4);
    run_phase(3, 0, 110, 1'b0, 1'b1, 6);
    run_phase(6, 300, 110, 1'b1, 1'b1, 4);
    run_phase(16, 5, 220, 1'b1, 1'b1, 3);
    run_phase(2, 2, 150, 1'b0, 1'b0, 4);
  endtask

  initial begin : main_sequence
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_full_backpressure();
    test_random_segments();
    wait_idle();
    if (err_cnt == 0) begin
      $display("** segment_max_pooling_unit: PASSED **");
    end else begin
      $display("** segment_max_pooling_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/smp_pkg.sv
rtl/core/smp_ram.sv
rtl/core/smp_cfg_regs.sv
rtl/core/smp_pool_core.sv
rtl/core/segment_max_pooling_unit.sv
tb/testbench.sv
